// ===== rtl/rsob_pkg.sv =====
// rsob_pkg: types, register indexes and arithmetic helpers for the rgba
// source-over blend unit; no dependencies, used by rtl/rgba_source_over_blend_unit.sv
`default_nettype none

package rsob_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_OVER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_STRAIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_STRAIGHT = 2'd2;

  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // pipeline depth: 4 blend stages, 3 divider stages, 1 output stage
  localparam int unsigned NUM_DIV    = 3;
  localparam int unsigned NUM_STAGES = NUM_DIV + 5;

  // four channels, alpha in lane 3
  typedef logic [3:0][7:0] pix_t;

  // one colour lane of the restoring divider
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] nlo;
    logic [7:0] q;
  } div_lane_t;

  // payload of one divider stage
  typedef struct packed {
    pix_t                 raw;
    pix_t                 bl;
    div_lane_t [2:0]      ln;
    logic      [2:0]      sat;
  } div_stage_t;

  // exact floor(x / 255) for x up to 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  // clamp a 9-bit sum to 255
  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? CHAN_MAX : v[7:0];
  endfunction

  // one restoring division step: shift in the next numerator bit
  function automatic div_lane_t div_step(input div_lane_t l, input logic [7:0] a);
    logic [8:0] t;
    div_lane_t  o;
    t     = {l.rem, l.nlo[7]};
    o.nlo = {l.nlo[6:0], 1'b0};
    if (t >= {1'b0, a}) begin
      o.rem = 8'(t - {1'b0, a});
      o.q   = {l.q[6:0], 1'b1};
    end else begin
      o.rem = t[7:0];
      o.q   = {l.q[6:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgba_source_over_blend_unit.sv =====
// rgba_source_over_blend_unit: source-over compositing of rgba8 pixels
// an accepted input beat passes through blend stages a to d, the divider stages and the output stage
// throughput: one beat per clock; the pipeline only stalls when the output
//   stage is full and out_tready is low, empty stages keep filling
// reset (rst_n low, synchronous): all stage valid bits cleared, blend_over=1,
//   dest_straight_alpha=0, src_straight_alpha=0
// depends on rtl/rsob_pkg.sv
`default_nettype none

module rgba_source_over_blend_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // src_ch0, src_ch1, src_ch2, src_alpha, dst_ch0, dst_ch1, dst_ch2, dst_alpha
  input  wire logic [63:0] in_tdata,
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_ch0, out_ch1, out_ch2, out_alpha
  output logic [31:0]      out_tdata,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [rsob_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        cfg_wdata
);

  // configuration registers
  logic blend_over_r, dest_straight_r, src_straight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_over_r    <= 1'b1;
      dest_straight_r <= 1'b0;
      src_straight_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsob_pkg::REG_BLEND_OVER:    blend_over_r    <= cfg_wdata;
        rsob_pkg::REG_DEST_STRAIGHT: dest_straight_r <= cfg_wdata;
        rsob_pkg::REG_SRC_STRAIGHT:  src_straight_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage ready chain
  logic [rsob_pkg::NUM_STAGES-1:0] vld_r;
  logic [rsob_pkg::NUM_STAGES:0]   rdy;

  always_comb begin
    rdy[rsob_pkg::NUM_STAGES] = out_tready;
    for (int k = rsob_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < rsob_pkg::NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];

  // payload registers
  rsob_pkg::pix_t sa_r, da_r;            // stage a: raw pixels
  logic [2:0][15:0] sp_r, dp_r;          // stage a: premultiply products
  rsob_pkg::pix_t sb_r, spm_b_r, dpm_b_r; // stage b: raw src, premultiplied
  rsob_pkg::pix_t sc_r, spm_c_r;         // stage c: raw src, premultiplied src
  logic [3:0][15:0] bp_r;                // stage c: dst * (255 - src alpha)
  rsob_pkg::pix_t sd_r, bl_d_r;          // stage d: raw src, blend result
  rsob_pkg::div_stage_t dv_r [rsob_pkg::NUM_DIV];
  rsob_pkg::pix_t out_r;

  rsob_pkg::pix_t in_src, in_dst;
  assign in_src = in_tdata[31:0];
  assign in_dst = in_tdata[63:32];

  // next values
  logic [2:0][15:0] sp_nxt, dp_nxt;
  rsob_pkg::pix_t spm_nxt, dpm_nxt, bl_nxt, out_nxt;
  logic [3:0][15:0] bp_nxt;
  rsob_pkg::div_stage_t dv_nxt [rsob_pkg::NUM_DIV];
  rsob_pkg::div_lane_t  fin_ln [3];

  always_comb begin
    // stage a: colour times own alpha
    for (int i = 0; i < 3; i++) begin
      sp_nxt[i] = 16'(in_src[i]) * 16'(in_src[3]);
      dp_nxt[i] = 16'(in_dst[i]) * 16'(in_dst[3]);
    end

    // stage b: divide by 255 where the operand holds straight alpha
    spm_nxt = sa_r;
    dpm_nxt = da_r;
    for (int i = 0; i < 3; i++) begin
      if (src_straight_r) spm_nxt[i] = rsob_pkg::div255(sp_r[i]);
      if (dest_straight_r) dpm_nxt[i] = rsob_pkg::div255(dp_r[i]);
    end

    // stage c: destination weighted by inverse source alpha
    for (int i = 0; i < 4; i++) begin
      bp_nxt[i] = 16'(dpm_b_r[i]) * 16'(rsob_pkg::CHAN_MAX - spm_b_r[3]);
    end

    // stage d: add source and saturate
    for (int i = 0; i < 4; i++) begin
      bl_nxt[i] = rsob_pkg::sat8({1'b0, spm_c_r[i]} +
                                 {1'b0, rsob_pkg::div255(bp_r[i])});
    end

    // divider stages: quotient of c*255 by alpha, two bits per stage
    for (int k = 0; k < rsob_pkg::NUM_DIV; k++) begin
      if (k == 0) begin
        dv_nxt[k].raw = sd_r;
        dv_nxt[k].bl  = bl_d_r;
        for (int i = 0; i < 3; i++) begin
          logic [15:0] n;
          n = {bl_d_r[i], 8'd0} - {8'd0, bl_d_r[i]};
          dv_nxt[k].ln[i]  = '{rem: n[15:8], nlo: n[7:0], q: 8'd0};
          dv_nxt[k].sat[i] = bl_d_r[i] > bl_d_r[3];
        end
      end else begin
        dv_nxt[k] = dv_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        dv_nxt[k].ln[i] = rsob_pkg::div_step(dv_nxt[k].ln[i], dv_nxt[k].bl[3]);
        dv_nxt[k].ln[i] = rsob_pkg::div_step(dv_nxt[k].ln[i], dv_nxt[k].bl[3]);
      end
    end

    // output stage: last two quotient bits and mode select
    for (int i = 0; i < 3; i++) begin
      fin_ln[i] = rsob_pkg::div_step(dv_r[rsob_pkg::NUM_DIV-1].ln[i],
                                     dv_r[rsob_pkg::NUM_DIV-1].bl[3]);
      fin_ln[i] = rsob_pkg::div_step(fin_ln[i], dv_r[rsob_pkg::NUM_DIV-1].bl[3]);
    end
    if (!blend_over_r) begin
      out_nxt = dv_r[rsob_pkg::NUM_DIV-1].raw;
    end else if (!dest_straight_r) begin
      out_nxt = dv_r[rsob_pkg::NUM_DIV-1].bl;
    end else begin
      out_nxt[3] = dv_r[rsob_pkg::NUM_DIV-1].bl[3];
      for (int i = 0; i < 3; i++) begin
        if (dv_r[rsob_pkg::NUM_DIV-1].bl[3] == 8'd0) begin
          out_nxt[i] = 8'd0;
        end else if (dv_r[rsob_pkg::NUM_DIV-1].sat[i]) begin
          out_nxt[i] = rsob_pkg::CHAN_MAX;
        end else begin
          out_nxt[i] = fin_ln[i].q;
        end
      end
    end
  end

  // payload loads, each stage when it can take a beat
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sa_r <= in_src;
      da_r <= in_dst;
      sp_r <= sp_nxt;
      dp_r <= dp_nxt;
    end
    if (rdy[1]) begin
      sb_r    <= sa_r;
      spm_b_r <= spm_nxt;
      dpm_b_r <= dpm_nxt;
    end
    if (rdy[2]) begin
      sc_r    <= sb_r;
      spm_c_r <= spm_b_r;
      bp_r    <= bp_nxt;
    end
    if (rdy[3]) begin
      sd_r   <= sc_r;
      bl_d_r <= bl_nxt;
    end
    for (int k = 0; k < rsob_pkg::NUM_DIV; k++) begin
      if (rdy[4+k]) dv_r[k] <= dv_nxt[k];
    end
    if (rdy[rsob_pkg::NUM_STAGES-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[rsob_pkg::NUM_STAGES-1];
  assign out_tdata  = out_r;

endmodule

`default_nettype wire

// ===== rtl/rsob_checker.sv =====
// rsob_checker: port-level assertions for rgba_source_over_blend_unit,
// attached by a bind statement at the end of this file
`default_nettype none

module rsob_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // a stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a free output stage means the whole pipeline can take a beat
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled although output side drains");

  // the first beat after reset needs the full pipeline latency
  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid [*8])
    else $error("output appeared with no pipeline latency");

endmodule

bind rgba_source_over_blend_unit rsob_checker u_rsob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
